### rtl/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and constants of the segment average logger.
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int LOG_DAYS   = 8;
  localparam int SEGS       = 8;
  localparam int COUNT_BITS = 16;
  localparam int SUM_W      = 24;
  localparam int ROW_W      = (LOG_DAYS > 1) ? $clog2(LOG_DAYS) : 1;
  localparam int ENTRIES    = LOG_DAYS * SEGS;
  localparam int ADDR_W     = $clog2(ENTRIES);

  localparam int SEC_PER_DAY = 86400;
  localparam int SEC_PER_SEG = 10800;
  localparam int TIME_W      = 32;
  localparam int DAY_STEPS   = TIME_W;
  localparam int SEG_STEPS   = 3;
  localparam int AVG_STEPS   = SUM_W;

  localparam logic [3:0] FAIL_MAX = 4'd15;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_FAILURE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_CEILING   = 1'd1;

  typedef struct packed {
    logic        command;
    logic        sensor_ok;
    logic [7:0]  temp_reading;
    logic [7:0]  humi_reading;
    logic [31:0] time_seconds;
    logic [2:0]  read_day;
    logic [2:0]  read_segment;
  } item_t;

  typedef struct packed {
    logic        refresh_ok;
    logic [7:0]  held_temp;
    logic [7:0]  held_humi;
    logic [15:0] day_number;
    logic [2:0]  segment_index;
    logic [6:0]  avg_temp;
    logic [6:0]  avg_humi;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

### rtl/sal_avg_div.sv
// ----------------------------------------------------------------------------
// sal_avg_div
// Bit-serial restoring divide of a segment sum by its reading count, one
// quotient bit per cycle while step is high, the quotient clamped to the ceiling.
// ----------------------------------------------------------------------------
module sal_avg_div (
  input  logic                            clk,
  input  sal_pkg::div_ctrl_t              ctrl,
  input  logic [sal_pkg::SUM_W-1:0]       dividend,
  input  logic [sal_pkg::COUNT_BITS-1:0]  divisor,
  input  logic [6:0]                      ceiling,
  output logic [6:0]                      avg
);
  import sal_pkg::*;

  logic [SUM_W-1:0]      dvd;
  logic [COUNT_BITS-1:0] dsr;
  logic [COUNT_BITS-1:0] rem;
  logic [6:0]            quot;
  logic                  over;
  logic [COUNT_BITS:0]   trial;
  logic                  ge;

  assign trial = {rem, dvd[SUM_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      quot <= '0;
      over <= 1'b0;
    end else if (ctrl.step) begin
      rem  <= ge ? COUNT_BITS'(trial - {1'b0, dsr}) : trial[COUNT_BITS-1:0];
      quot <= {quot[5:0], ge};
      over <= over | quot[6];
      dvd  <= {dvd[SUM_W-2:0], 1'b0};
    end
  end

  assign avg = (over || quot > ceiling) ? ceiling : quot;

endmodule

### rtl/segment_average_logger_top.sv
// ----------------------------------------------------------------------------
// segment_average_logger_top
// Sensor reading holder with a day log of three-hour segment averages.
// ----------------------------------------------------------------------------
// One item is worked at a time. A sample item runs the bit-serial divide of
// the time by the day length (32 steps, then 3 for the segment) and, when it
// is logged, the two bit-serial average divides running side by side (24
// steps); a read item goes straight to the memory read. The log keeps its
// rows in a circular memory with one registered read port; a new day
// advances the row pointer and clears the row's entry flags together,
// so no clearing pass follows reset.
module segment_average_logger_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  sal_pkg::item_t                     item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output sal_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sal_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sal_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sal_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DAY   = 3'd1;
  localparam logic [2:0] S_SEG   = 3'd2;
  localparam logic [2:0] S_ACCUM = 3'd3;
  localparam logic [2:0] S_AVG   = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [4:0] cnt;

  logic [3:0] failure_limit;
  logic [6:0] average_ceiling;

  logic [3:0]            fail_count;
  logic [7:0]            held_temperature;
  logic [7:0]            held_humidity;
  logic [2:0]            last_segment;
  logic [COUNT_BITS-1:0] reading_count;
  logic [SUM_W-1:0]      temp_sum;
  logic [SUM_W-1:0]      humi_sum;
  logic [15:0]           day_dates [LOG_DAYS];
  logic [ROW_W-1:0]      head;
  logic [ENTRIES-1:0]    entry_valid;
  logic [13:0]           avg_mem [ENTRIES];
  logic [13:0]           mem_q;
  logic                  mem_q_valid;

  logic       cmd;
  logic       store_en;
  logic       ok_flag;
  logic [2:0] rday;
  logic [2:0] rseg;

  logic [TIME_W-1:0] secs_sr;
  logic [16:0]       day_rem;
  logic [15:0]       day_q;
  logic [2:0]        seg_q;

  logic [3:0]  fail_upd;
  logic [3:0]  fail_count_next;
  logic [7:0]  held_temperature_next;
  logic [7:0]  held_humidity_next;
  logic        exceeded;
  logic        store_next;

  logic [17:0] day_trial;
  logic        day_ge;
  logic [16:0] seg_div;
  logic        seg_ge;

  logic [ROW_W-1:0] newest;
  logic [ROW_W-1:0] head_next;
  logic [ROW_W-1:0] read_row;
  logic [ROW_W:0]   row_sum;
  logic [ADDR_W-1:0] newest_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rday_in_range;

  logic                  restart;
  logic [SUM_W-1:0]      temp_base;
  logic [SUM_W-1:0]      humi_base;
  logic [COUNT_BITS-1:0] count_base;
  logic [SUM_W:0]        temp_add;
  logic [SUM_W:0]        humi_add;
  logic [COUNT_BITS:0]   count_add;
  logic [SUM_W-1:0]      temp_sum_next;
  logic [SUM_W-1:0]      humi_sum_next;
  logic [COUNT_BITS-1:0] reading_count_next;

  div_ctrl_t  div_ctrl;
  logic [6:0] temp_avg;
  logic [6:0] humi_avg;
  result_t    result_next;
  logic       accept;

  assign item_stall = state != S_IDLE;
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    if (item.sensor_ok) begin
      fail_upd              = '0;
      held_temperature_next = item.temp_reading;
      held_humidity_next    = item.humi_reading;
    end else begin
      fail_upd              = (fail_count < FAIL_MAX) ? fail_count + 4'd1 : fail_count;
      held_temperature_next = held_temperature;
      held_humidity_next    = held_humidity;
    end
    exceeded        = fail_upd > failure_limit;
    fail_count_next = fail_upd;
    if (exceeded) begin
      fail_count_next       = failure_limit;
      held_temperature_next = '0;
      held_humidity_next    = '0;
    end
    store_next = !exceeded && held_temperature_next != '0 && held_humidity_next != '0;
  end

  assign day_trial = {day_rem, secs_sr[TIME_W-1]};
  assign day_ge    = day_trial >= 18'(SEC_PER_DAY);

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    seg_div = 17'(SEC_PER_SEG * 4);
      2'd1:    seg_div = 17'(SEC_PER_SEG * 2);
      default: seg_div = 17'(SEC_PER_SEG);
    endcase
  end
  assign seg_ge = day_rem >= seg_div;

  assign newest    = (head == '0) ? ROW_W'(LOG_DAYS - 1) : head - 1'b1;
  assign head_next = (head == ROW_W'(LOG_DAYS - 1)) ? '0 : head + 1'b1;
  assign row_sum   = {1'b0, head} + {1'b0, ROW_W'(rday)};
  assign read_row  = (row_sum >= (ROW_W + 1)'(LOG_DAYS)) ?
                     ROW_W'(row_sum - (ROW_W + 1)'(LOG_DAYS)) : row_sum[ROW_W-1:0];
  assign rday_in_range = int'(rday) < LOG_DAYS;
  assign newest_addr   = ADDR_W'({newest, seg_q});
  assign rd_addr       = (cmd == CMD_SAMPLE) ? newest_addr : ADDR_W'({read_row, rseg});

  assign restart    = seg_q != last_segment;
  assign temp_base  = restart ? '0 : temp_sum;
  assign humi_base  = restart ? '0 : humi_sum;
  assign count_base = restart ? '0 : reading_count;
  assign temp_add   = {1'b0, temp_base} + {{(SUM_W - 7){1'b0}}, held_temperature};
  assign humi_add   = {1'b0, humi_base} + {{(SUM_W - 7){1'b0}}, held_humidity};
  assign count_add  = {1'b0, count_base} + {{COUNT_BITS{1'b0}}, 1'b1};
  assign temp_sum_next      = temp_add[SUM_W] ? '1 : temp_add[SUM_W-1:0];
  assign humi_sum_next      = humi_add[SUM_W] ? '1 : humi_add[SUM_W-1:0];
  assign reading_count_next = count_add[COUNT_BITS] ? '1 : count_add[COUNT_BITS-1:0];

  assign div_ctrl.load = state == S_ACCUM;
  assign div_ctrl.step = state == S_AVG;

  sal_avg_div u_temp_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (temp_sum_next),
    .divisor  (reading_count_next),
    .ceiling  (average_ceiling),
    .avg      (temp_avg)
  );

  sal_avg_div u_humi_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (humi_sum_next),
    .divisor  (reading_count_next),
    .ceiling  (average_ceiling),
    .avg      (humi_avg)
  );

  always_comb begin
    result_next.held_temp = held_temperature;
    result_next.held_humi = held_humidity;
    if (cmd == CMD_SAMPLE) begin
      result_next.refresh_ok    = ok_flag;
      result_next.day_number    = day_q;
      result_next.segment_index = seg_q;
      result_next.avg_temp      = mem_q_valid ? mem_q[13:7] : '0;
      result_next.avg_humi      = mem_q_valid ? mem_q[6:0] : '0;
    end else begin
      result_next.refresh_ok    = 1'b1;
      result_next.day_number    = rday_in_range ? day_dates[ROW_W'(rday)] : '0;
      result_next.segment_index = rseg;
      result_next.avg_temp      = (rday_in_range && mem_q_valid) ? mem_q[13:7] : '0;
      result_next.avg_humi      = (rday_in_range && mem_q_valid) ? mem_q[6:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      avg_mem[newest_addr] <= {temp_avg, humi_avg};
    end
    if (state == S_READ) begin
      mem_q <= avg_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= item.command;
      rday    <= item.read_day;
      rseg    <= item.read_segment;
      secs_sr <= item.time_seconds;
    end
    unique case (state)
      S_IDLE: begin
        day_rem <= '0;
      end
      S_DAY: begin
        day_rem <= day_ge ? 17'(day_trial - 18'(SEC_PER_DAY)) : day_trial[16:0];
        day_q   <= {day_q[14:0], day_ge};
        secs_sr <= {secs_sr[TIME_W-2:0], 1'b0};
      end
      S_SEG: begin
        day_rem <= seg_ge ? day_rem - seg_div : day_rem;
        seg_q   <= {seg_q[1:0], seg_ge};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      cnt              <= '0;
      failure_limit    <= 4'd10;
      average_ceiling  <= 7'd99;
      fail_count       <= '0;
      held_temperature <= '0;
      held_humidity    <= '0;
      last_segment     <= '0;
      reading_count    <= '0;
      temp_sum         <= '0;
      humi_sum         <= '0;
      head             <= '0;
      entry_valid      <= '0;
      mem_q_valid      <= 1'b0;
      store_en         <= 1'b0;
      ok_flag          <= 1'b1;
      result_valid     <= 1'b0;
      for (int i = 0; i < LOG_DAYS; i++) begin
        day_dates[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FAILURE_LIMIT: failure_limit   <= cfg_data[3:0];
          REG_AVG_CEILING:   average_ceiling <= cfg_data[6:0];
          default: begin
          end
        endcase
      end

      result_valid <= (state == S_DONE) || (result_valid && result_stall);

      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            if (item.command == CMD_SAMPLE) begin
              fail_count       <= fail_count_next;
              held_temperature <= held_temperature_next;
              held_humidity    <= held_humidity_next;
              store_en         <= store_next;
              ok_flag          <= !exceeded;
              state            <= S_DAY;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_DAY: begin
          if (cnt == 5'(DAY_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_SEG;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_SEG: begin
          if (cnt == 5'(SEG_STEPS - 1)) begin
            cnt   <= '0;
            state <= store_en ? S_ACCUM : S_READ;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_ACCUM: begin
          if (day_q != day_dates[LOG_DAYS-1]) begin
            for (int i = 0; i < LOG_DAYS - 1; i++) begin
              day_dates[i] <= day_dates[i+1];
            end
            day_dates[LOG_DAYS-1] <= day_q;
            head <= head_next;
            for (int i = 0; i < ENTRIES; i++) begin
              if (i / SEGS == int'(head)) begin
                entry_valid[i] <= 1'b0;
              end
            end
          end
          last_segment  <= seg_q;
          temp_sum      <= temp_sum_next;
          humi_sum      <= humi_sum_next;
          reading_count <= reading_count_next;
          cnt           <= '0;
          state         <= S_AVG;
        end
        S_AVG: begin
          if (cnt == 5'(AVG_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_WRITE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_WRITE: begin
          entry_valid[newest_addr] <= 1'b1;
          state <= S_READ;
        end
        S_READ: begin
          mem_q_valid <= entry_valid[rd_addr];
          state       <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!result_valid || !result_stall)) begin
      result <= result_next;
    end
  end

endmodule

### rtl/sal_checker.sv
// ----------------------------------------------------------------------------
// sal_checker
// Port-level checks of the segment average logger, bound to the top level.
// ----------------------------------------------------------------------------
module sal_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_valid,
  input logic                               item_stall,
  input logic                               result_valid,
  input logic                               result_stall,
  input sal_pkg::result_t                   result
);

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second item taken while one is in work");

  a_fail_zeroes_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.refresh_ok |-> result.held_temp == 8'd0 &&
      result.held_humi == 8'd0)
    else $error("held values not zeroed on failure limit");

endmodule

bind segment_average_logger_top sal_checker u_sal_checker (.*);
